// ===== sv/dll_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dll_pkg;
  typedef enum logic [3:0] {
    K_INS_FRONT = 4'd0, K_INS_POS = 4'd1, K_INS_END = 4'd2, K_INS_BEFORE = 4'd3,
    K_INS_AFTER = 4'd4, K_DEL_HEAD = 4'd5, K_DEL_POS = 4'd6, K_DEL_TAIL = 4'd7,
    K_SEARCH = 4'd8, K_REVERSE = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_RANGE = 3'd2, ST_FULL = 3'd3, ST_NOTFOUND = 3'd4
  } status_t;

  localparam int KIND_W   = 4;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;
endpackage
`default_nettype wire

// ===== sv/dll_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface dll_req_if;
  logic                           valid;
  logic                           ready;
  logic [dll_pkg::KIND_W-1:0]     kind;
  logic signed [dll_pkg::DATA_W-1:0] target;
  logic signed [dll_pkg::DATA_W-1:0] value;
  modport source (output valid, kind, target, value, input ready);
  modport sink   (input valid, kind, target, value, output ready);
endinterface

interface dll_rsp_if #(parameter int CW = 9);
  logic                             valid;
  logic                             ready;
  logic [dll_pkg::STATUS_W-1:0]     status;
  logic [CW-1:0]                    found_position;
  logic [CW-1:0]                    element_count;
  modport source (output valid, status, found_position, element_count, input ready);
  modport sink   (input valid, status, found_position, element_count, output ready);
endinterface
`default_nettype wire

// ===== sv/doubly_linked_list_manager.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Doubly linked list manager.
// in: request word (kind, target, value); out: one response word per request
// (status, found_position, element_count). Handshakes are valid/ready.
// One request at a time. Slot data and links live in one synchronous memory
// (one read, one write per cycle, read data in the cycle after the address); a
// free-slot stack sits in a second memory. Each slot walked passes through
// address, data and step states. Slots walked: for positional ops up to
// CAPACITY/2 from the nearer end, for key insert and search up to the match
// position, for reverse the whole list.
// After reset a clearing pass fills the free stack, one slot per cycle;
// in.ready stays low until the pass is done.
// The response sits in an output register; while out.ready is low the block
// holds it and takes no new request.
module doubly_linked_list_manager #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dll_req_if.sink   in,
  dll_rsp_if.source out
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] NIL = CW'(CAPACITY);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] val;
    logic [CW-1:0]          nxt;
    logic [CW-1:0]          prv;
  } node_t;

  typedef enum logic [11:0] {
    S_INIT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_DEC   = 12'b000000000100,
    S_RD    = 12'b000000001000,
    S_WAIT  = 12'b000000010000,
    S_STEP  = 12'b000000100000,
    S_FPOP  = 12'b000001000000,
    S_FWT   = 12'b000010000000,
    S_LINK  = 12'b000100000000,
    S_FIX   = 12'b001000000000,
    S_FIX2  = 12'b010000000000,
    S_RESP  = 12'b100000000000
  } state_t;

  // walk modes
  typedef enum logic [3:0] {
    W_POS  = 4'b0001,
    W_FIND = 4'b0010,
    W_REV  = 4'b0100,
    W_DEL  = 4'b1000
  } walk_t;

  node_t nmem [CAPACITY];
  logic [AW-1:0] fmem [CAPACITY];

  state_t state_r, state_nxt;
  walk_t  walk_r, walk_nxt;
  logic [dll_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt, key_r, key_nxt;
  logic [CW-1:0] pos_r, pos_nxt, idx_r, idx_nxt, cur_r, cur_nxt;
  logic dir_r, dir_nxt; // 1: walking prev links
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt, ftop_r, ftop_nxt;
  logic [CW-1:0] p_r, p_nxt, n_r, n_nxt, s_r, s_nxt;
  logic [CW-1:0] fixa_r, fixa_nxt, fixb_r, fixb_nxt;
  logic ins_r, ins_nxt;
  logic [dll_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic [CW-1:0] fpos_r, fpos_nxt;
  logic ovld_r, ovld_nxt;

  // memory ports
  logic          nrd_en, nwr_en;
  logic [AW-1:0] nrd_a, nwr_a;
  node_t         nwr_d, nrd_q;
  logic          fwr_en;
  logic [AW-1:0] frd_a, fwr_a, fwr_d, frd_q;
  // field patch: which field (next or prev) of the read node to write back
  logic          fix_is_nxt_r, fix_is_nxt_nxt;

  always_ff @(posedge clk) begin
    if (nwr_en) nmem[nwr_a] <= nwr_d;
    if (nrd_en) nrd_q <= nmem[nrd_a];
  end

  always_ff @(posedge clk) begin
    if (fwr_en) fmem[fwr_a] <= fwr_d;
    frd_q <= fmem[frd_a];
  end

  logic signed [dll_pkg::DATA_W:0] tpos_s;
  logic [VALUE_WIDTH-1:0] in_val_ext, in_key_ext;
  always_comb begin
    tpos_s     = {in.target[dll_pkg::DATA_W-1], in.target};
    in_val_ext = VALUE_WIDTH'({{VALUE_WIDTH{in.value[dll_pkg::DATA_W-1]}}, in.value});
    in_key_ext = VALUE_WIDTH'({{VALUE_WIDTH{in.target[dll_pkg::DATA_W-1]}}, in.target});
  end

  assign in.ready           = (state_r == S_IDLE) && !ovld_r;
  assign out.valid          = ovld_r;
  assign out.status         = st_r;
  assign out.found_position = fpos_r;
  assign out.element_count  = cnt_r;

  always_comb begin
    state_nxt = state_r; walk_nxt = walk_r; kind_nxt = kind_r;
    val_nxt = val_r; key_nxt = key_r; pos_nxt = pos_r; idx_nxt = idx_r;
    cur_nxt = cur_r; dir_nxt = dir_r; head_nxt = head_r; tail_nxt = tail_r;
    cnt_nxt = cnt_r; ftop_nxt = ftop_r; p_nxt = p_r; n_nxt = n_r; s_nxt = s_r;
    fixa_nxt = fixa_r; fixb_nxt = fixb_r; ins_nxt = ins_r; st_nxt = st_r;
    fpos_nxt = fpos_r; ovld_nxt = ovld_r; fix_is_nxt_nxt = fix_is_nxt_r;
    nrd_en = 1'b0; nrd_a = cur_r[AW-1:0];
    nwr_en = 1'b0; nwr_a = cur_r[AW-1:0]; nwr_d = nrd_q;
    fwr_en = 1'b0; fwr_a = ftop_r[AW-1:0]; fwr_d = cur_r[AW-1:0];
    frd_a = AW'(ftop_r - CW'(1));

    if (ovld_r && out.ready) ovld_nxt = 1'b0;

    case (state_r)
      S_INIT: begin
        fwr_en = 1'b1;
        fwr_a  = cur_r[AW-1:0];
        fwr_d  = cur_r[AW-1:0];
        cur_nxt = cur_r + CW'(1);
        if (cur_r == NIL - CW'(1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in.valid && in.ready) begin
          kind_nxt = in.kind;
          val_nxt  = in_val_ext;
          key_nxt  = in_key_ext;
          st_nxt   = dll_pkg::ST_OK;
          fpos_nxt = '0;
          ins_nxt  = 1'b0;
          // positions outside 1..CAPACITY stay 0 and are rejected in S_DEC
          pos_nxt  = '0;
          if (tpos_s >= 1 && tpos_s <= (dll_pkg::DATA_W+1)'(CAPACITY))
            pos_nxt = tpos_s[CW-1:0];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_RESP;
        if (kind_r <= dll_pkg::K_INS_AFTER && cnt_r == NIL) st_nxt = dll_pkg::ST_FULL;
        else case (kind_r)
          dll_pkg::K_INS_FRONT: begin
            ins_nxt = 1'b1; p_nxt = NIL; n_nxt = head_r; state_nxt = S_FPOP;
          end
          dll_pkg::K_INS_END: begin
            ins_nxt = 1'b1; p_nxt = tail_r; n_nxt = NIL; state_nxt = S_FPOP;
          end
          dll_pkg::K_INS_POS: begin
            if (pos_r == '0 || pos_r > cnt_r + CW'(1)) st_nxt = dll_pkg::ST_RANGE;
            else begin
              ins_nxt = 1'b1;
              if (pos_r == CW'(1)) begin
                p_nxt = NIL; n_nxt = head_r; state_nxt = S_FPOP;
              end else if (pos_r == cnt_r + CW'(1)) begin
                p_nxt = tail_r; n_nxt = NIL; state_nxt = S_FPOP;
              end else begin
                // find slot at pos-1 (its next is the one at pos)
                pos_nxt = pos_r - CW'(1);
                walk_nxt = W_POS; state_nxt = S_RD;
                if ((pos_r - CW'(1)) <= (cnt_r >> 1)) begin
                  dir_nxt = 1'b0; cur_nxt = head_r; idx_nxt = CW'(1);
                end else begin
                  dir_nxt = 1'b1; cur_nxt = tail_r; idx_nxt = cnt_r;
                end
              end
            end
          end
          dll_pkg::K_INS_BEFORE, dll_pkg::K_INS_AFTER, dll_pkg::K_SEARCH: begin
            if (cnt_r == '0) st_nxt = dll_pkg::ST_NOTFOUND;
            else begin
              if (kind_r == dll_pkg::K_SEARCH) key_nxt = val_r;
              walk_nxt = W_FIND; dir_nxt = 1'b0; cur_nxt = head_r; idx_nxt = CW'(1);
              state_nxt = S_RD;
            end
          end
          dll_pkg::K_DEL_HEAD, dll_pkg::K_DEL_TAIL, dll_pkg::K_DEL_POS: begin
            if (cnt_r == '0) st_nxt = dll_pkg::ST_EMPTY;
            else if (kind_r == dll_pkg::K_DEL_HEAD) begin
              walk_nxt = W_DEL; cur_nxt = head_r; state_nxt = S_RD;
            end else if (kind_r == dll_pkg::K_DEL_TAIL) begin
              walk_nxt = W_DEL; cur_nxt = tail_r; state_nxt = S_RD;
            end else if (pos_r == '0 || pos_r > cnt_r) st_nxt = dll_pkg::ST_RANGE;
            else begin
              walk_nxt = W_POS; state_nxt = S_RD;
              if (pos_r <= (cnt_r >> 1)) begin
                dir_nxt = 1'b0; cur_nxt = head_r; idx_nxt = CW'(1);
              end else begin
                dir_nxt = 1'b1; cur_nxt = tail_r; idx_nxt = cnt_r;
              end
            end
          end
          dll_pkg::K_REVERSE: begin
            if (cnt_r == '0) st_nxt = dll_pkg::ST_EMPTY;
            else begin
              walk_nxt = W_REV; cur_nxt = head_r; idx_nxt = CW'(1); state_nxt = S_RD;
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        nrd_en = 1'b1; nrd_a = cur_r[AW-1:0]; state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_STEP;
      S_STEP: begin
        case (walk_r)
          W_POS: begin
            if (idx_r == pos_r) begin
              if (ins_r) begin
                p_nxt = cur_r; n_nxt = nrd_q.nxt; state_nxt = S_FPOP;
              end else begin
                walk_nxt = W_DEL; state_nxt = S_STEP;
              end
            end else begin
              cur_nxt = dir_r ? nrd_q.prv : nrd_q.nxt;
              idx_nxt = dir_r ? idx_r - CW'(1) : idx_r + CW'(1);
              state_nxt = S_RD;
            end
          end
          W_FIND: begin
            if (nrd_q.val == key_r) begin
              if (kind_r == dll_pkg::K_SEARCH) begin
                fpos_nxt = idx_r; state_nxt = S_RESP;
              end else begin
                ins_nxt = 1'b1;
                if (kind_r == dll_pkg::K_INS_BEFORE) begin
                  p_nxt = nrd_q.prv; n_nxt = cur_r;
                end else begin
                  p_nxt = cur_r; n_nxt = nrd_q.nxt;
                end
                state_nxt = S_FPOP;
              end
            end else if (idx_r == cnt_r || nrd_q.nxt == NIL) begin
              st_nxt = dll_pkg::ST_NOTFOUND; state_nxt = S_RESP;
            end else begin
              cur_nxt = nrd_q.nxt; idx_nxt = idx_r + CW'(1); state_nxt = S_RD;
            end
          end
          W_REV: begin
            nwr_en = 1'b1; nwr_a = cur_r[AW-1:0];
            nwr_d = '{val: nrd_q.val, nxt: nrd_q.prv, prv: nrd_q.nxt};
            if (idx_r == cnt_r || nrd_q.nxt == NIL) begin
              head_nxt = tail_r; tail_nxt = head_r; state_nxt = S_RESP;
            end else begin
              cur_nxt = nrd_q.nxt; idx_nxt = idx_r + CW'(1); state_nxt = S_RD;
            end
          end
          default: begin // delete cur: push slot, patch neighbors
            p_nxt = nrd_q.prv; n_nxt = nrd_q.nxt;
            fwr_en = 1'b1; fwr_a = ftop_r[AW-1:0]; fwr_d = cur_r[AW-1:0];
            ftop_nxt = ftop_r + CW'(1);
            cnt_nxt = cnt_r - CW'(1);
            if (nrd_q.prv == NIL) head_nxt = nrd_q.nxt;
            if (nrd_q.nxt == NIL) tail_nxt = nrd_q.prv;
            fixa_nxt = nrd_q.prv; fixb_nxt = nrd_q.nxt;
            ins_nxt = 1'b0; s_nxt = cur_r;
            state_nxt = S_FIX;
          end
        endcase
      end
      S_FPOP: begin
        frd_a = AW'(ftop_r - CW'(1)); state_nxt = S_FWT;
      end
      S_FWT: begin
        s_nxt = CW'(frd_q); ftop_nxt = ftop_r - CW'(1); state_nxt = S_LINK;
      end
      S_LINK: begin
        nwr_en = 1'b1; nwr_a = s_r[AW-1:0];
        nwr_d = '{val: val_r, nxt: n_r, prv: p_r};
        cnt_nxt = cnt_r + CW'(1);
        if (p_r == NIL) head_nxt = s_r;
        if (n_r == NIL) tail_nxt = s_r;
        fixa_nxt = p_r; fixb_nxt = n_r;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        // read prev-side neighbor (patch next link), else next-side (patch prev)
        if (fixa_r != NIL) begin
          nrd_en = 1'b1; nrd_a = fixa_r[AW-1:0]; cur_nxt = fixa_r;
          fix_is_nxt_nxt = 1'b1; state_nxt = S_FIX2;
        end else if (fixb_r != NIL) begin
          nrd_en = 1'b1; nrd_a = fixb_r[AW-1:0]; cur_nxt = fixb_r;
          fix_is_nxt_nxt = 1'b0; state_nxt = S_FIX2;
        end else state_nxt = S_RESP;
      end
      S_FIX2: begin
        nwr_en = 1'b1; nwr_a = cur_r[AW-1:0];
        nwr_d = nrd_q;
        if (fix_is_nxt_r) begin
          nwr_d.nxt = ins_r ? s_r : n_r;
          fixa_nxt = NIL;
        end else begin
          nwr_d.prv = ins_r ? s_r : p_r;
          fixb_nxt = NIL;
        end
        // fix state re-entered; the read of the other neighbor is issued there
        state_nxt = S_FIX;
      end
      S_RESP: begin
        if (!ovld_r || out.ready) begin
          ovld_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; cur_r <= '0; ftop_r <= NIL; head_r <= NIL; tail_r <= NIL;
      cnt_r <= '0; ovld_r <= 1'b0; walk_r <= W_POS;
    end else begin
      state_r <= state_nxt; cur_r <= cur_nxt; ftop_r <= ftop_nxt; head_r <= head_nxt;
      tail_r <= tail_nxt; cnt_r <= cnt_nxt; ovld_r <= ovld_nxt; walk_r <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; val_r <= val_nxt; key_r <= key_nxt; pos_r <= pos_nxt;
    idx_r <= idx_nxt; dir_r <= dir_nxt; p_r <= p_nxt; n_r <= n_nxt; s_r <= s_nxt;
    fixa_r <= fixa_nxt; fixb_r <= fixb_nxt; ins_r <= ins_nxt; st_r <= st_nxt;
    fpos_r <= fpos_nxt; fix_is_nxt_r <= fix_is_nxt_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r + ftop_r == NIL))
    else $error("count and free stack out of step");
  a_empty_nil: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cnt_r == '0) |-> (head_r == NIL && tail_r == NIL))
    else $error("empty list with live head or tail");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out.ready) |=> (ovld_r && $stable(st_r) && $stable(cnt_r)))
    else $error("response changed while stalled");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/doubly_linked_list_manager_test.sv =====
`timescale 1ns / 1ps
module doubly_linked_list_manager_test;

  localparam int CAP = 256;
  localparam int LIMIT_CYCLES = 5000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  dll_req_if req_ch ();
  dll_rsp_if #(.CW(9)) rsp_ch ();

  doubly_linked_list_manager #(.CAPACITY(CAP), .VALUE_WIDTH(32)) dut (
    .clk(clk), .rst_n(rst_n), .in(req_ch.sink), .out(rsp_ch.source)
  );

  typedef struct packed {
    dll_pkg::status_t status;
    logic [8:0] found_position;
    logic [8:0] element_count;
  } reply_t;

  // Plain array copy of the list; values kept in order, head first.
  class list_scoreboard;
    logic [31:0] items[$];
    reply_t replies_due[$];
    int errors;
    int checked;

    function void note_request(logic [3:0] kind, logic signed [31:0] target,
                               logic signed [31:0] value);
      reply_t r;
      int pos;
      int cnt;
      r.status = dll_pkg::ST_OK;
      r.found_position = '0;
      pos = -1;
      cnt = items.size();
      if (kind <= dll_pkg::K_INS_AFTER && cnt >= CAP) begin
        r.status = dll_pkg::ST_FULL;
      end else begin
        case (kind)
          dll_pkg::K_INS_FRONT: items.push_front(value);
          dll_pkg::K_INS_POS: begin
            if (target < 1 || target > cnt + 1) r.status = dll_pkg::ST_RANGE;
            else items.insert(target - 1, value);
          end
          dll_pkg::K_INS_END: items.push_back(value);
          dll_pkg::K_INS_BEFORE, dll_pkg::K_INS_AFTER: begin
            foreach (items[i]) if (pos < 0 && items[i] == target) pos = i;
            if (pos < 0) r.status = dll_pkg::ST_NOTFOUND;
            else items.insert(kind == dll_pkg::K_INS_BEFORE ? pos : pos + 1, value);
          end
          dll_pkg::K_DEL_HEAD, dll_pkg::K_DEL_POS, dll_pkg::K_DEL_TAIL: begin
            if (cnt == 0) r.status = dll_pkg::ST_EMPTY;
            else if (kind == dll_pkg::K_DEL_HEAD) void'(items.pop_front());
            else if (kind == dll_pkg::K_DEL_TAIL) void'(items.pop_back());
            else if (target < 1 || target > cnt) r.status = dll_pkg::ST_RANGE;
            else items.delete(target - 1);
          end
          dll_pkg::K_SEARCH: begin
            foreach (items[i]) if (pos < 0 && items[i] == value) pos = i;
            if (pos < 0) r.status = dll_pkg::ST_NOTFOUND;
            else r.found_position = pos + 1;
          end
          dll_pkg::K_REVERSE: begin
            if (cnt == 0) r.status = dll_pkg::ST_EMPTY;
            else items.reverse();
          end
          default: ;
        endcase
      end
      r.element_count = items.size();
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [2:0] st, logic [8:0] fp, logic [8:0] ec);
      reply_t e;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply st=%0d pos=%0d cnt=%0d", $time, st, fp, ec);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      checked++;
      if (st !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, st);
        errors++;
      end
      if (fp !== e.found_position) begin
        $display("%0t: found_position expected %0d got %0d", $time, e.found_position, fp);
        errors++;
      end
      if (ec !== e.element_count) begin
        $display("%0t: element_count expected %0d got %0d", $time, e.element_count, ec);
        errors++;
      end
    endfunction
  endclass

  list_scoreboard sb = new();
  int cycles = 0;
  int rx_hold = 0;
  bit sending_done = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind = '0;
    req_ch.target = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off window.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_reply(rsp_ch.status, rsp_ch.found_position, rsp_ch.element_count);
  end

  initial begin
    int w;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // valid stays high after an accept until the next word or idle gap replaces it
  task automatic send_word(logic [3:0] kind, logic signed [31:0] target,
                           logic signed [31:0] value, bit no_gap = 0);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 5);
    if (w > 0) begin
      req_ch.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.target <= target;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(kind, target, value);
  endtask

  // Mostly small values so keys and searches hit; sometimes full range.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 30)) - 15;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_pos(int n);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 0;
      2: return n + 1;
      3: return n + 2;
      default: return $urandom_range(1, n + 1);
    endcase
  endfunction

  task automatic random_word(int bias_ins);
    int k;
    int n;
    logic signed [31:0] key;
    n = sb.items.size();
    k = $urandom_range(0, 99);
    if (k < bias_ins) k = $urandom_range(0, 4);
    else if (k < 97) k = $urandom_range(5, 9);
    else k = $urandom_range(10, 15);
    key = (n > 0 && $urandom_range(0, 3) != 0) ? sb.items[$urandom_range(0, n - 1)]
                                               : pick_value();
    case (k)
      dll_pkg::K_INS_POS, dll_pkg::K_DEL_POS: send_word(k, pick_pos(n), pick_value());
      dll_pkg::K_INS_BEFORE, dll_pkg::K_INS_AFTER: send_word(k, key, pick_value());
      dll_pkg::K_SEARCH: send_word(k, $urandom, key);
      default: send_word(k, $urandom, pick_value());
    endcase
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases, extremes, every kind.
    send_word(dll_pkg::K_DEL_HEAD, 0, 0);
    send_word(dll_pkg::K_DEL_POS, 1, 0);
    send_word(dll_pkg::K_DEL_TAIL, 0, 0);
    send_word(dll_pkg::K_REVERSE, 0, 0);
    send_word(dll_pkg::K_SEARCH, 0, 5);
    send_word(dll_pkg::K_INS_BEFORE, 5, 1);
    send_word(dll_pkg::K_INS_POS, 0, 1);
    send_word(dll_pkg::K_INS_POS, 2, 1);
    send_word(dll_pkg::K_INS_POS, 1, 32'sh7fffffff);
    send_word(dll_pkg::K_INS_AFTER, 3, 9);
    send_word(dll_pkg::K_INS_BEFORE, 32'sh7fffffff, 32'sh80000000);
    send_word(dll_pkg::K_INS_AFTER, 32'sh7fffffff, -1);
    send_word(dll_pkg::K_INS_FRONT, 0, 0);
    send_word(dll_pkg::K_INS_END, 0, 32'h5555aaaa);
    send_word(dll_pkg::K_INS_POS, 6, 7);
    send_word(dll_pkg::K_INS_POS, 32'sh80000000, 7);
    send_word(dll_pkg::K_SEARCH, 0, -1);
    send_word(dll_pkg::K_SEARCH, 0, 32'sh80000000);
    send_word(dll_pkg::K_REVERSE, 0, 0);
    send_word(dll_pkg::K_DEL_POS, 0, 0);
    send_word(dll_pkg::K_DEL_POS, 7, 0);
    send_word(dll_pkg::K_DEL_POS, 3, 0);
    send_word(4'd15, -1, -1);
    send_word(dll_pkg::K_DEL_HEAD, 0, 0);
    send_word(dll_pkg::K_DEL_TAIL, 0, 0);

    // Back-pressure: receiver stalls long while words keep coming.
    rx_hold = 300;
    for (i = 0; i < 20; i++) send_word(dll_pkg::K_INS_END, 0, $urandom_range(0, 9), 1);

    // Fill to capacity, hit full on every insert kind, then drain to four items.
    while (sb.items.size() < CAP) send_word(dll_pkg::K_INS_FRONT, 0, $urandom);
    send_word(dll_pkg::K_INS_FRONT, 0, 1);
    send_word(dll_pkg::K_INS_POS, 1, 1);
    send_word(dll_pkg::K_INS_END, 0, 1);
    send_word(dll_pkg::K_INS_BEFORE, sb.items[0], 1);
    send_word(dll_pkg::K_INS_AFTER, sb.items[0], 1);
    send_word(dll_pkg::K_SEARCH, 0, sb.items[CAP - 1]);
    send_word(dll_pkg::K_REVERSE, 0, 0);
    send_word(dll_pkg::K_DEL_POS, CAP, 0);
    while (sb.items.size() > 4) send_word(dll_pkg::K_DEL_TAIL, 0, 0);

    // Random: insert-heavy and delete-heavy phases with random content.
    for (i = 0; i < 300; i++) random_word((i / 150) % 2 ? 35 : 65);
    req_ch.valid <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("Checked %0d replies over all request kinds, incl. full, empty and stall.",
             sb.checked);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/dll_pkg.sv
sv/dll_if.sv
sv/doubly_linked_list_manager.sv
tb/sv/doubly_linked_list_manager_test.sv
